/* src/omsm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// One-mismatch substring matcher package
// Request and result types, the queue entry type and fixed field widths.
// ----------------------------------------------------------------------------
package omsm_pkg;

	localparam int LETTER_W = 5;
	localparam int INDEX_W  = 6;
	localparam int LEN_W    = 7;
	localparam int START_W  = 20;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [0:0] REG_PATTERN_LENGTH = 1'b0;
	localparam logic [LEN_W-1:0] PATTERN_LENGTH_RESET = 7'd1;

	localparam logic CMD_PATTERN = 1'b0;
	localparam logic CMD_TEXT    = 1'b1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic               command;
		logic [INDEX_W-1:0] pattern_index;
		logic [LETTER_W-1:0] letter;
		logic               start_of_text;
	} req_t;

	typedef struct packed {
		logic [START_W-1:0] match_start;
		logic               exact_match;
	} result_t;

	typedef enum logic {
		OP_PATTERN = 1'b0,
		OP_TEXT    = 1'b1
	} op_kind_t;

	typedef struct packed {
		op_kind_t            kind;
		logic [INDEX_W-1:0]  index;
		logic [LETTER_W-1:0] letter;
		logic                start_of_text;
	} op_t;

endpackage

/* src/omsm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matcher front end
// Accepts requests, drops pattern writes to slots that do not exist and
// queues the rest for the execution pipeline.
// ----------------------------------------------------------------------------
module omsm_front import omsm_pkg::*; #(
	parameter int PATTERN_MAX = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  logic req_valid,
	output logic req_ready,
	output op_t  op,
	output logic op_valid,
	input  logic op_ready
);

	op_t                    queue_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   keep;
	logic                   push;
	logic                   pop;
	op_t                    entry;

	always_comb begin
		keep = (req.command == CMD_TEXT) || (int'(req.pattern_index) < PATTERN_MAX);
		entry.kind          = (req.command == CMD_TEXT) ? OP_TEXT : OP_PATTERN;
		entry.index         = req.pattern_index;
		entry.letter        = req.letter;
		entry.start_of_text = req.start_of_text;
	end

	assign req_ready = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
	assign op_valid  = (count_q != '0);
	assign op        = queue_q[rd_ptr_q];
	assign push      = req_valid && req_ready && keep;
	assign pop       = op_valid && op_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QUEUE_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QUEUE_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= entry;
		end
	end

endmodule

/* src/omsm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matcher execution pipeline
// Writes pattern letters, shifts the text window, compares every window
// position with the pattern in parallel and registers the result.
// ----------------------------------------------------------------------------
module omsm_back import omsm_pkg::*; #(
	parameter int PATTERN_MAX = 64,
	parameter int TEXT_MAX    = 1048576
) (
	input  logic             clk,
	input  logic             arst_n,
	input  op_t              op,
	input  logic             op_valid,
	output logic             op_ready,
	input  logic [LEN_W-1:0] pattern_length,
	output result_t          result,
	output logic             result_valid,
	input  logic             result_ready
);

	localparam int IW  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int SW  = $clog2(TEXT_MAX + 1);
	localparam int PW  = $clog2(PATTERN_MAX + 1);
	localparam int MW0 = (SW > LEN_W) ? SW : LEN_W;
	localparam int CW  = ((MW0 > PW) ? MW0 : PW) + 1;

	logic [LETTER_W-1:0]    pattern_q [PATTERN_MAX];
	logic [LETTER_W-1:0]    window_q  [PATTERN_MAX];
	logic [SW-1:0]          seen_q;

	logic                   valid_s1;
	logic [START_W-1:0]     start_s1;
	logic [IW-1:0]          len_m1_s1;
	logic                   valid_s2;
	logic [START_W-1:0]     start_s2;
	logic [PATTERN_MAX-1:0] mm_s2;
	logic                   result_valid_q;
	result_t                result_q;

	logic                   adv;
	logic                   take;
	logic                   is_text;
	logic [CW-1:0]          eff_len;
	logic [IW-1:0]          len_m1;
	logic [SW-1:0]          seen_base;
	logic [SW-1:0]          seen_next;
	logic                   room;
	logic                   hit;
	logic [START_W-1:0]     start;
	logic [PATTERN_MAX-1:0] mm;
	logic                   at_most_one;
	logic                   no_miss;

	assign adv          = !result_valid_q || result_ready;
	assign op_ready     = adv;
	assign take         = op_valid && adv;
	assign is_text      = (op.kind == OP_TEXT);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		if (pattern_length == '0) begin
			eff_len = CW'(1);
		end else if (CW'(pattern_length) > CW'(PATTERN_MAX)) begin
			eff_len = CW'(PATTERN_MAX);
		end else begin
			eff_len = CW'(pattern_length);
		end
		len_m1    = IW'(eff_len - CW'(1));
		seen_base = op.start_of_text ? '0 : seen_q;
		room      = CW'(seen_base) < CW'(TEXT_MAX);
		seen_next = seen_base + SW'(1);
		hit       = is_text && room && (CW'(seen_next) >= eff_len);
		start     = START_W'(CW'(seen_next) - eff_len);
	end

	always_comb begin
		for (int k = 0; k < PATTERN_MAX; k++) begin
			mm[k] = (IW'(k) <= len_m1_s1) &&
				(pattern_q[k] != window_q[IW'(len_m1_s1 - IW'(k))]);
		end
		no_miss     = (mm_s2 == '0);
		at_most_one = ((mm_s2 & (mm_s2 - PATTERN_MAX'(1))) == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				window_q[i] <= '0;
			end
			seen_q         <= '0;
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (take && is_text) begin
				window_q[0] <= op.letter;
				for (int i = 1; i < PATTERN_MAX; i++) begin
					window_q[i] <= window_q[i-1];
				end
				seen_q <= room ? seen_next : seen_base;
			end
			if (adv) begin
				valid_s1       <= take && hit;
				valid_s2       <= valid_s1;
				result_valid_q <= valid_s2 && at_most_one;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !is_text) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				if (int'(op.index) == k) begin
					pattern_q[k] <= op.letter;
				end
			end
		end
		if (adv) begin
			start_s1             <= start;
			len_m1_s1            <= len_m1;
			start_s2             <= start_s1;
			mm_s2                <= mm;
			result_q.match_start <= start_s2;
			result_q.exact_match <= no_miss;
		end
	end

endmodule

/* src/one_mismatch_substring_matcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// One-mismatch substring matcher
// Reports each text position where the recent text equals the stored pattern
// with at most one substituted letter.
// ----------------------------------------------------------------------------
// Requests enter on req with req_valid and req_ready. A request with command
// 0 writes one pattern letter; with command 1 it feeds one text letter, and
// start_of_text restarts the position count. Results leave on result with
// result_valid and result_ready: the start position of the matching window
// and whether the match is exact. pattern_length is written over the APB
// port at byte address 0. It must be written only while no request is in
// flight; the block does not enforce this. One request is taken per cycle
// while the request queue is not full. A result passes through the request
// queue, the window shift, the parallel compare and the output register.
// When result_ready is low with a result waiting, the pipeline holds, and
// the two-entry queue still takes requests until it is full.
// Reset clears the text window, the position count and the pipeline, and sets
// pattern_length to 1. Pattern letters are undefined until written.
// ----------------------------------------------------------------------------
module one_mismatch_substring_matcher import omsm_pkg::*; #(
	parameter int PATTERN_MAX = 64,
	parameter int TEXT_MAX    = 1048576
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  req_t                  req,
	input  logic                  req_valid,
	output logic                  req_ready,
	output result_t               result,
	output logic                  result_valid,
	input  logic                  result_ready,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [LEN_W-1:0] pattern_length_q;
	logic             cfg_write;
	op_t              op;
	logic             op_valid;
	logic             op_ready;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= PATTERN_LENGTH_RESET;
		end else if (cfg_write && (paddr[2] == REG_PATTERN_LENGTH)) begin
			pattern_length_q <= pwdata[LEN_W-1:0];
		end
	end

	always_comb begin
		case (paddr[2])
			REG_PATTERN_LENGTH: begin
				prdata = APB_DATA_W'(pattern_length_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	omsm_front #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.op       (op),
		.op_valid (op_valid),
		.op_ready (op_ready)
	);

	omsm_back #(
		.PATTERN_MAX(PATTERN_MAX),
		.TEXT_MAX   (TEXT_MAX)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.op_valid      (op_valid),
		.op_ready      (op_ready),
		.pattern_length(pattern_length_q),
		.result        (result),
		.result_valid  (result_valid),
		.result_ready  (result_ready)
	);

endmodule

/* src/omsm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matcher port checker
// Watches the top-level ports for handshake, backpressure and register
// readback behavior.
// ----------------------------------------------------------------------------
module omsm_checker import omsm_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input req_t                  req,
	input logic                  req_valid,
	input logic                  req_ready,
	input result_t               result,
	input logic                  result_valid,
	input logic                  result_ready,
	input logic                  psel,
	input logic                  penable,
	input logic                  pwrite,
	input logic [APB_ADDR_W-1:0] paddr,
	input logic [APB_DATA_W-1:0] pwdata,
	input logic [APB_DATA_W-1:0] prdata,
	input logic                  pready
);

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("Request changed while stalled.");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("Result changed while stalled.");

	a_full_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> result_valid)
		else $error("Request queue full without a waiting result.");

	a_length_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite && (paddr[2] == REG_PATTERN_LENGTH) &&
		$past(psel && penable && pwrite && pready && (paddr[2] == REG_PATTERN_LENGTH))
		|-> prdata[LEN_W-1:0] == $past(pwdata[LEN_W-1:0]))
		else $error("Pattern length readback differs from last write.");

endmodule

bind one_mismatch_substring_matcher omsm_checker u_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the one-mismatch substring matcher
// Streams pattern writes and text letters through the request channel with
// random idling on both sides. A local copy of the pattern, the text window
// and the position count predicts each match, and every result is checked
// in order. The length register is rewritten between phases over APB.
// ----------------------------------------------------------------------------
module tb_top;
	import omsm_pkg::*;

	localparam int PATTERN_MAX   = 64;
	localparam int TEXT_MAX      = 1048576;
	localparam int RANDOM_ITEMS  = 800;
	localparam int STREAM_ITEMS  = 150;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int PRINT_LIMIT   = 40;
	localparam logic [APB_ADDR_W-1:0] LENGTH_ADDR = APB_ADDR_W'({REG_PATTERN_LENGTH, 2'b00});

	logic                  clk;
	logic                  arst_n;
	req_t                  req;
	logic                  req_valid;
	logic                  req_ready;
	result_t               result;
	logic                  result_valid;
	logic                  result_ready;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	logic [LETTER_W-1:0] pattern_copy [PATTERN_MAX];
	logic [LETTER_W-1:0] window_ring [PATTERN_MAX];
	logic [5:0]          ring_head;
	int                  letters_seen_cnt;
	logic [LEN_W-1:0]    length_reg;
	result_t             expected_matches [$];
	result_t             want;

	bit idle_on;
	int sink_hold_cycles;
	int cycles;
	int errors;
	int pattern_writes;
	int text_letters;
	int results_checked;

	one_mismatch_substring_matcher #(
		.PATTERN_MAX(PATTERN_MAX),
		.TEXT_MAX   (TEXT_MAX)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.result      (result),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycles,
				expected_matches.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("MISMATCH at cycle %0d: %s", cycles, msg);
	endtask

	function automatic int active_length();
		if (length_reg == 0)
			return 1;
		if (length_reg > PATTERN_MAX)
			return PATTERN_MAX;
		return int'(length_reg);
	endfunction

	task automatic predict_request(input req_t r);
		int eff;
		int diffs;
		logic [5:0] slot;
		result_t res;
		if (r.command == CMD_PATTERN) begin
			pattern_copy[r.pattern_index] = r.letter;
			pattern_writes++;
			return;
		end
		text_letters++;
		if (r.start_of_text)
			letters_seen_cnt = 0;
		ring_head = ring_head + 6'd1;
		window_ring[ring_head] = r.letter;
		if (letters_seen_cnt >= TEXT_MAX)
			return;
		letters_seen_cnt++;
		eff = active_length();
		if (letters_seen_cnt < eff)
			return;
		diffs = 0;
		for (int k = 0; k < eff; k++) begin
			slot = ring_head - 6'(eff - 1 - k);
			if (pattern_copy[k] != window_ring[slot])
				diffs++;
		end
		if (diffs > 1)
			return;
		res.match_start = START_W'(letters_seen_cnt - eff);
		res.exact_match = (diffs == 0);
		expected_matches = {expected_matches, res};
	endtask

	function automatic logic [LETTER_W-1:0] random_letter();
		if ($urandom_range(0, 7) == 0)
			return LETTER_W'($urandom_range(26, 31));
		return LETTER_W'($urandom_range(0, 25));
	endfunction

	function automatic req_t text_letter(input logic [LETTER_W-1:0] l, input logic sot);
		req_t r;
		r.command       = CMD_TEXT;
		r.pattern_index = INDEX_W'($urandom_range(0, 63));
		r.letter        = l;
		r.start_of_text = sot;
		return r;
	endfunction

	function automatic req_t pattern_letter(input logic [INDEX_W-1:0] idx,
			input logic [LETTER_W-1:0] l, input logic sot);
		req_t r;
		r.command       = CMD_PATTERN;
		r.pattern_index = idx;
		r.letter        = l;
		r.start_of_text = sot;
		return r;
	endfunction

	task automatic send_request(input req_t r);
		int gap;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		@(negedge clk);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		predict_request(r);
	endtask

	task automatic drain_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_matches.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apb_read(input logic [APB_ADDR_W-1:0] addr,
			output logic [APB_DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_length_readback();
		logic [APB_DATA_W-1:0] readback;
		apb_read(LENGTH_ADDR, readback);
		if (readback[LEN_W-1:0] !== length_reg)
			report_mismatch($sformatf("pattern_length reads %0d, wrote %0d",
				readback[LEN_W-1:0], length_reg));
	endtask

	task automatic set_length(input logic [LEN_W-1:0] value);
		drain_results();
		apb_write(LENGTH_ADDR, APB_DATA_W'(value));
		length_reg = value;
		check_length_readback();
	endtask

	// Result sink: random stalls per result, plus one long hold on request.
	initial begin
		int stall;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = idle_on ? $urandom_range(0, 5) : 0;
			if (sink_hold_cycles != 0) begin
				stall = sink_hold_cycles;
				sink_hold_cycles = 0;
			end
			@(negedge clk);
			if (stall != 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			results_checked++;
			if (expected_matches.size() == 0) begin
				report_mismatch($sformatf("unexpected result start %0d exact %0b",
					result.match_start, result.exact_match));
			end else begin
				want = expected_matches.pop_front();
				if (result.match_start !== want.match_start)
					report_mismatch($sformatf("match_start %0d, predicted %0d",
						result.match_start, want.match_start));
				if (result.exact_match !== want.exact_match)
					report_mismatch($sformatf("exact_match %0b, predicted %0b at start %0d",
						result.exact_match, want.exact_match, want.match_start));
			end
		end
	end

	task automatic test_reset_length();
		length_reg = PATTERN_LENGTH_RESET;
		check_length_readback();
	endtask

	task automatic test_pattern_preload();
		for (int k = 0; k < PATTERN_MAX; k++)
			send_request(pattern_letter(INDEX_W'(k), random_letter(), 1'($urandom_range(0, 1))));
	endtask

	task automatic test_exact_and_single();
		set_length(7'd3);
		send_request(pattern_letter(6'd0, 5'd2, 1'b0));
		send_request(pattern_letter(6'd1, 5'd0, 1'b1));
		send_request(pattern_letter(6'd2, 5'd25, 1'b0));
		send_request(text_letter(5'd2, 1'b1));
		send_request(text_letter(5'd0, 1'b0));
		send_request(text_letter(5'd25, 1'b0));
		send_request(text_letter(5'd2, 1'b0));
		send_request(text_letter(5'd0, 1'b0));
		send_request(text_letter(5'd24, 1'b0));
		send_request(text_letter(5'd31, 1'b0));
		send_request(text_letter(5'd31, 1'b0));
		send_request(text_letter(5'd31, 1'b0));
		send_request(text_letter(5'd2, 1'b0));
		send_request(text_letter(5'd31, 1'b0));
		send_request(text_letter(5'd25, 1'b0));
		send_request(pattern_letter(6'd2, 5'd31, 1'b1));
		send_request(text_letter(5'd2, 1'b0));
		send_request(text_letter(5'd0, 1'b0));
		send_request(text_letter(5'd31, 1'b0));
	endtask

	task automatic test_length_extremes();
		set_length(7'd0);
		send_request(text_letter(random_letter(), 1'b1));
		repeat (3) send_request(text_letter(random_letter(), 1'b0));
		set_length(7'd127);
		send_request(text_letter(random_letter(), 1'b1));
		repeat (4) send_request(text_letter(random_letter(), 1'b0));
		set_length(7'd65);
		send_request(text_letter(random_letter(), 1'b1));
	endtask

	task automatic test_backpressure();
		set_length(7'd1);
		sink_hold_cycles = 300;
		send_request(text_letter(random_letter(), 1'b1));
		repeat (40) send_request(text_letter(random_letter(), 1'b0));
	endtask

	task automatic test_back_to_back();
		set_length(7'd1);
		send_request(pattern_letter(6'd0, random_letter(), 1'b0));
		idle_on = 1'b0;
		send_request(text_letter(random_letter(), 1'b1));
		repeat (STREAM_ITEMS)
			send_request(text_letter(LETTER_W'($urandom_range(0, 31)), 1'b0));
		drain_results();
		idle_on = 1'b1;
	endtask

	task automatic test_random_texts();
		int done;
		int eff;
		int pick;
		int m1;
		int m2;
		logic [LEN_W-1:0] len_value;
		logic [LETTER_W-1:0] l;
		done = 0;
		while (done < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 15);
			if (pick == 0)
				len_value = 7'd64;
			else if (pick == 1)
				len_value = 7'd0;
			else if (pick == 2)
				len_value = LEN_W'($urandom_range(65, 127));
			else if (pick == 3)
				len_value = LEN_W'($urandom_range(9, 63));
			else
				len_value = LEN_W'($urandom_range(1, 8));
			set_length(len_value);
			eff = active_length();
			for (int k = 0; k < eff; k++) begin
				send_request(pattern_letter(INDEX_W'(k), random_letter(),
					1'($urandom_range(0, 1))));
				done++;
			end
			repeat ($urandom_range(1, 3)) begin
				send_request(text_letter(random_letter(), 1'b1));
				done++;
				repeat ($urandom_range(2, 6)) begin
					pick = $urandom_range(0, 9);
					if (pick < 6) begin
						// Pattern copy with zero, one or two substituted letters.
						m1 = (pick < 2) ? -1 : $urandom_range(0, eff - 1);
						m2 = (pick == 5) ? $urandom_range(0, eff - 1) : -1;
						for (int k = 0; k < eff; k++) begin
							l = pattern_copy[k];
							if (k == m1 || k == m2)
								l = l + LETTER_W'($urandom_range(1, 31));
							send_request(text_letter(l, 1'b0));
							done++;
						end
					end else if (pick < 8) begin
						repeat ($urandom_range(1, eff + 3)) begin
							send_request(text_letter(random_letter(), 1'b0));
							done++;
						end
					end else if (pick == 8) begin
						send_request(pattern_letter(INDEX_W'($urandom_range(0, eff - 1)),
							random_letter(), 1'($urandom_range(0, 1))));
						done++;
					end else begin
						// Broken copy: a prefix cut short, then a random letter that may restart the text.
						for (int k = 0; k < $urandom_range(0, eff - 1); k++) begin
							send_request(text_letter(pattern_copy[k], 1'b0));
							done++;
						end
						send_request(text_letter(random_letter(), 1'($urandom_range(0, 1))));
						done++;
					end
				end
			end
		end
	endtask

	initial begin
		idle_on          = 1'b1;
		sink_hold_cycles = 0;
		cycles           = 0;
		errors           = 0;
		pattern_writes   = 0;
		text_letters     = 0;
		results_checked  = 0;
		ring_head        = '0;
		letters_seen_cnt = 0;
		length_reg       = PATTERN_LENGTH_RESET;
		for (int k = 0; k < PATTERN_MAX; k++) begin
			pattern_copy[k] = '0;
			window_ring[k]  = '0;
		end
		arst_n    = 1'b0;
		req       = '0;
		req_valid = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_length();
		test_pattern_preload();
		test_exact_and_single();
		test_length_extremes();
		test_backpressure();
		test_random_texts();
		test_back_to_back();
		drain_results();

		$display("Sent %0d pattern writes and %0d text letters; %0d results checked.",
			pattern_writes, text_letters, results_checked);
		$display("Lengths 0 to 127, a long output stall and an unbroken back-to-back stream.");
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
